FILE: design/swsp_pkg.sv
// ----------------------------------------------------------------------------
// swsp_pkg: shared types and constants of the shell word splitter
// Character width, register reset values, register indexes, scan modes and
// the entry format of the queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

package swsp_pkg;

    localparam int CHAR_W      = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [CHAR_W-1:0] WORD_CNT_MAX = 8'd255;

    // register reset values
    localparam logic [CHAR_W-1:0] DELIM_FIRST_RST  = 8'd32;
    localparam logic [CHAR_W-1:0] DELIM_SECOND_RST = 8'd9;
    localparam logic [CHAR_W-1:0] QUOTE_CHAR_RST   = 8'd34;
    localparam logic [CHAR_W-1:0] ESCAPE_CHAR_RST  = 8'd92;
    localparam logic [CHAR_W-1:0] MAX_ARGS_RST     = 8'd255;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DELIM_FIRST  = 3'd0,
        CFG_DELIM_SECOND = 3'd1,
        CFG_QUOTE_CHAR   = 3'd2,
        CFG_ESCAPE_CHAR  = 3'd3,
        CFG_MAX_ARGS     = 3'd4
    } cfg_reg_t;

    // input opcodes
    typedef enum logic {
        OP_CHAR = 1'b0,
        OP_EOL  = 1'b1
    } opcode_t;

    // scan modes
    typedef enum logic [1:0] {
        MODE_LINE_START = 2'd0,
        MODE_BETWEEN    = 2'd1,
        MODE_PLAIN      = 2'd2,
        MODE_QUOTED     = 2'd3
    } scan_mode_t;

    // one result slot, already masked for dropped words
    typedef struct packed {
        logic [CHAR_W-1:0] out_ch;
        logic              char_valid;
        logic              word_end;
    } slot_t;

    // one queue entry: all results of one input item
    typedef struct packed {
        logic              two;
        slot_t             slot0;
        slot_t             slot1;
        logic [CHAR_W-1:0] word_index;
        logic              dropped;
    } entry_t;

    // queue status toward front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

FILE: design/swsp_if.sv
// ----------------------------------------------------------------------------
// swsp_if: channel interfaces of the shell word splitter
// Valid/ready channels for input characters and for word results.
// ----------------------------------------------------------------------------
`default_nettype none

interface swsp_in_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [swsp_pkg::CHAR_W-1:0] ch;

    modport source (output valid, output opcode, output ch, input ready);
    modport sink   (input valid, input opcode, input ch, output ready);
endinterface

interface swsp_out_if;
    logic                        valid;
    logic                        ready;
    logic [swsp_pkg::CHAR_W-1:0] out_ch;
    logic                        char_valid;
    logic                        word_end;
    logic [swsp_pkg::CHAR_W-1:0] word_index;
    logic                        dropped;
    logic                        last;

    modport source (output valid, output out_ch, output char_valid, output word_end,
                    output word_index, output dropped, output last, input ready);
    modport sink   (input valid, input out_ch, input char_valid, input word_end,
                    input word_index, input dropped, input last, output ready);
endinterface

`default_nettype wire

FILE: design/swsp_front.sv
// ----------------------------------------------------------------------------
// swsp_front: character classifier and scan state
// Holds the configuration registers and the scan state, classifies each
// accepted character and pushes all of its results as one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module swsp_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    swsp_in_if.sink                              cmd_line,
    input  wire logic                            cfg_wr_en,
    input  wire logic [swsp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [swsp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire swsp_pkg::q_status_t             q_status,
    output logic                                 push,
    output swsp_pkg::entry_t                     push_entry
);

    logic [swsp_pkg::CHAR_W-1:0] delim_first_reg;
    logic [swsp_pkg::CHAR_W-1:0] delim_second_reg;
    logic [swsp_pkg::CHAR_W-1:0] quote_char_reg;
    logic [swsp_pkg::CHAR_W-1:0] escape_char_reg;
    logic [swsp_pkg::CHAR_W-1:0] max_args_reg;

    swsp_pkg::scan_mode_t        mode_reg, mode_next;
    logic                        held_reg, held_next;
    logic [swsp_pkg::CHAR_W-1:0] word_count_reg, word_count_next;

    logic                        accept;
    logic                        is_eol;
    logic                        is_delim;
    logic                        is_quote;
    logic                        is_esc;
    logic                        drop;
    logic                        has_result;
    logic [swsp_pkg::CHAR_W-1:0] word_count_inc;

    function automatic swsp_pkg::slot_t mk_slot(
        input logic [swsp_pkg::CHAR_W-1:0] c,
        input logic                        valid,
        input logic                        word_end,
        input logic                        dropped
    );
        swsp_pkg::slot_t s;
        s.char_valid = valid && !dropped;
        s.out_ch     = s.char_valid ? c : '0;
        s.word_end   = word_end;
        return s;
    endfunction

    // handshake and classification
    assign cmd_line.ready = !q_status.full;
    assign accept   = cmd_line.valid && cmd_line.ready;
    assign is_eol   = (swsp_pkg::opcode_t'(cmd_line.opcode) == swsp_pkg::OP_EOL);
    assign is_delim = (cmd_line.ch == delim_first_reg) || (cmd_line.ch == delim_second_reg);
    assign is_quote = (cmd_line.ch == quote_char_reg);
    assign is_esc   = (cmd_line.ch == escape_char_reg);
    assign drop     = (word_count_reg >= max_args_reg);
    assign word_count_inc = (word_count_reg != swsp_pkg::WORD_CNT_MAX)
                          ? word_count_reg + 1'b1 : word_count_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_first_reg  <= swsp_pkg::DELIM_FIRST_RST;
            delim_second_reg <= swsp_pkg::DELIM_SECOND_RST;
            quote_char_reg   <= swsp_pkg::QUOTE_CHAR_RST;
            escape_char_reg  <= swsp_pkg::ESCAPE_CHAR_RST;
            max_args_reg     <= swsp_pkg::MAX_ARGS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (swsp_pkg::cfg_reg_t'(cfg_index))
                swsp_pkg::CFG_DELIM_FIRST:  delim_first_reg  <= cfg_wdata;
                swsp_pkg::CFG_DELIM_SECOND: delim_second_reg <= cfg_wdata;
                swsp_pkg::CFG_QUOTE_CHAR:   quote_char_reg   <= cfg_wdata;
                swsp_pkg::CFG_ESCAPE_CHAR:  escape_char_reg  <= cfg_wdata;
                swsp_pkg::CFG_MAX_ARGS:     max_args_reg     <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= swsp_pkg::MODE_LINE_START;
            held_reg       <= 1'b0;
            word_count_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            held_reg       <= held_next;
            word_count_reg <= word_count_next;
        end
    end

    // next scan state
    always_comb
    begin
        mode_next       = mode_reg;
        held_next       = held_reg;
        word_count_next = word_count_reg;
        if (is_eol)
        begin
            mode_next       = swsp_pkg::MODE_LINE_START;
            held_next       = 1'b0;
            word_count_next = '0;
        end
        else
        begin
            unique case (mode_reg)
                swsp_pkg::MODE_LINE_START:
                begin
                    if (is_quote)
                        mode_next = swsp_pkg::MODE_QUOTED;
                    else if (is_delim)
                    begin
                        mode_next       = swsp_pkg::MODE_BETWEEN;
                        word_count_next = word_count_inc;
                    end
                    else
                    begin
                        mode_next = swsp_pkg::MODE_PLAIN;
                        held_next = is_esc;
                    end
                end
                swsp_pkg::MODE_BETWEEN:
                begin
                    if (is_delim)
                        mode_next = swsp_pkg::MODE_BETWEEN;
                    else if (is_quote)
                        mode_next = swsp_pkg::MODE_QUOTED;
                    else
                    begin
                        mode_next = swsp_pkg::MODE_PLAIN;
                        held_next = is_esc;
                    end
                end
                swsp_pkg::MODE_PLAIN:
                begin
                    if (is_delim)
                    begin
                        if (held_reg)
                            held_next = 1'b0;
                        else
                        begin
                            mode_next       = swsp_pkg::MODE_BETWEEN;
                            word_count_next = word_count_inc;
                        end
                    end
                    else
                        held_next = is_esc;
                end
                swsp_pkg::MODE_QUOTED:
                begin
                    if (is_quote)
                    begin
                        if (held_reg)
                            held_next = 1'b0;
                        else
                        begin
                            mode_next       = swsp_pkg::MODE_BETWEEN;
                            word_count_next = word_count_inc;
                        end
                    end
                    else
                        held_next = is_esc;
                end
            endcase
        end
    end

    // result slots of the accepted item
    always_comb
    begin
        logic word_chr;
        word_chr   = 1'b0;
        has_result = 1'b0;
        push_entry = '0;
        push_entry.word_index = word_count_reg;
        push_entry.dropped    = drop;
        if (is_eol)
        begin
            unique case (mode_reg)
                swsp_pkg::MODE_LINE_START:
                begin
                    has_result       = 1'b1;
                    push_entry.slot0 = mk_slot('0, 1'b0, 1'b1, drop);
                end
                swsp_pkg::MODE_PLAIN, swsp_pkg::MODE_QUOTED:
                begin
                    has_result       = 1'b1;
                    push_entry.slot0 = held_reg ? mk_slot(escape_char_reg, 1'b1, 1'b1, drop)
                                                : mk_slot('0, 1'b0, 1'b1, drop);
                end
                swsp_pkg::MODE_BETWEEN:
                begin
                    has_result = 1'b0;
                end
            endcase
        end
        else
        begin
            unique case (mode_reg)
                swsp_pkg::MODE_LINE_START:
                begin
                    if (!is_quote && is_delim)
                    begin
                        has_result       = 1'b1;
                        push_entry.slot0 = mk_slot('0, 1'b0, 1'b1, drop);
                    end
                    else if (!is_quote)
                        word_chr = 1'b1;
                end
                swsp_pkg::MODE_BETWEEN:
                begin
                    word_chr = !is_delim && !is_quote;
                end
                swsp_pkg::MODE_PLAIN:
                begin
                    if (is_delim)
                    begin
                        has_result       = 1'b1;
                        push_entry.slot0 = held_reg
                                         ? mk_slot(cmd_line.ch, 1'b1, 1'b0, drop)
                                         : mk_slot('0, 1'b0, 1'b1, drop);
                    end
                    else
                        word_chr = 1'b1;
                end
                swsp_pkg::MODE_QUOTED:
                begin
                    if (is_quote)
                    begin
                        has_result       = 1'b1;
                        push_entry.slot0 = held_reg
                                         ? mk_slot(cmd_line.ch, 1'b1, 1'b0, drop)
                                         : mk_slot('0, 1'b0, 1'b1, drop);
                    end
                    else
                        word_chr = 1'b1;
                end
            endcase
            // word character: flush a held escape, then emit or hold this one
            if (word_chr)
            begin
                if (held_reg)
                begin
                    has_result       = 1'b1;
                    push_entry.slot0 = mk_slot(escape_char_reg, 1'b1, 1'b0, drop);
                    if (!is_esc)
                    begin
                        push_entry.two   = 1'b1;
                        push_entry.slot1 = mk_slot(cmd_line.ch, 1'b1, 1'b0, drop);
                    end
                end
                else if (!is_esc)
                begin
                    has_result       = 1'b1;
                    push_entry.slot0 = mk_slot(cmd_line.ch, 1'b1, 1'b0, drop);
                end
            end
        end
    end

    assign push = accept && has_result;

`ifndef SYNTHESIS
    // a held escape exists only inside a word
    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> (mode_reg == swsp_pkg::MODE_PLAIN || mode_reg == swsp_pkg::MODE_QUOTED))
        else $error("held escape outside a word");

    // the word count restarts with every line
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == swsp_pkg::MODE_LINE_START) |-> (word_count_reg == '0))
        else $error("word count not cleared at line start");
`endif

endmodule

`default_nettype wire

FILE: design/swsp_queue.sv
// ----------------------------------------------------------------------------
// swsp_queue: entry queue between front and back
// Small flip-flop queue of per-item result entries; push and pop may
// happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swsp_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire swsp_pkg::entry_t     push_entry,
    input  wire logic                 pop,
    output swsp_pkg::entry_t          head,
    output swsp_pkg::q_status_t       q_status
);

    swsp_pkg::entry_t               entries_reg [swsp_pkg::Q_DEPTH];
    logic [swsp_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [swsp_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [swsp_pkg::Q_CNT_W-1:0]   count_reg, count_next;

    assign q_status.full  = (count_reg == swsp_pkg::Q_CNT_W'(swsp_pkg::Q_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head           = entries_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

`ifndef SYNTHESIS
    // occupancy stays within the storage
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= swsp_pkg::Q_CNT_W'(swsp_pkg::Q_DEPTH))
        else $error("queue occupancy out of range");
`endif

endmodule

`default_nettype wire

FILE: design/swsp_back.sv
// ----------------------------------------------------------------------------
// swsp_back: result sequencer
// Takes queue entries and presents their one or two results, one transfer
// per cycle while the output is ready, from an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swsp_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire swsp_pkg::entry_t     head,
    input  wire swsp_pkg::q_status_t  q_status,
    output logic                      pop,
    swsp_out_if.source                words
);

    logic                         out_valid_reg, out_valid_next;
    logic                         phase_reg, phase_next;
    swsp_pkg::slot_t              slot_reg, slot_next;
    logic [swsp_pkg::CHAR_W-1:0]  index_reg;
    logic                         dropped_reg;
    logic                         last_reg, last_next;
    logic                         load;

    assign load = !out_valid_reg || words.ready;

    // result selection from the head entry
    always_comb
    begin
        pop            = 1'b0;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !words.ready;
        slot_next      = head.slot0;
        last_next      = !head.two;
        if (load)
        begin
            out_valid_next = !q_status.empty;
            if (!q_status.empty)
            begin
                if (!phase_reg)
                begin
                    slot_next  = head.slot0;
                    last_next  = !head.two;
                    phase_next = head.two;
                    pop        = !head.two;
                end
                else
                begin
                    slot_next  = head.slot1;
                    last_next  = 1'b1;
                    phase_next = 1'b0;
                    pop        = 1'b1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load && !q_status.empty)
        begin
            slot_reg    <= slot_next;
            index_reg   <= head.word_index;
            dropped_reg <= head.dropped;
            last_reg    <= last_next;
        end
    end

    assign words.valid      = out_valid_reg;
    assign words.out_ch     = slot_reg.out_ch;
    assign words.char_valid = slot_reg.char_valid;
    assign words.word_end   = slot_reg.word_end;
    assign words.word_index = index_reg;
    assign words.dropped    = dropped_reg;
    assign words.last       = last_reg;

`ifndef SYNTHESIS
    // a pending second result keeps its entry at the queue head
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> !q_status.empty)
        else $error("second result pending with empty queue");

    // a shown first result of two means the second is still pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> phase_reg)
        else $error("non-last result without pending second result");
`endif

endmodule

`default_nettype wire

FILE: design/shell_word_splitter_core.sv
// ----------------------------------------------------------------------------
// shell_word_splitter_core: command line word splitter
// Splits a character stream into words with delimiter skipping, quoted
// words and escape handling; results carry word index and drop flag.
//
//   channel    role    carries
//   cmd_line   sink    opcode, ch (one character or end of line)
//   words      source  out_ch, char_valid, word_end, word_index, dropped, last
//   cfg_*      write   cfg_wr_en, cfg_index, cfg_wdata (five 8-bit registers)
//
// One character is taken per cycle while the queue is not full; an item
// with two results is sent as two transfers, since the back part sends one
// transfer per cycle while the output is ready. A transfer in passes the
// queue entry register, then the output register. A four-entry queue
// decouples the front from output stalls; the front stops taking characters only while that queue is full.
// Reset sets the registers to their defaults and the scan to line start.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_word_splitter_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    swsp_in_if.sink                               cmd_line,
    swsp_out_if.source                            words,
    input  wire logic                             cfg_wr_en,
    input  wire logic [swsp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [swsp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic                 push;
    logic                 pop;
    swsp_pkg::entry_t     push_entry;
    swsp_pkg::entry_t     head;
    swsp_pkg::q_status_t  q_status;

    // classify characters and track the scan
    swsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_line   (cmd_line),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // per-item result entries
    swsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    // emit results one transfer at a time
    swsp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .words    (words)
    );

endmodule

`default_nettype wire
